// File: design/assert_macros.svh
// Assertion helper macros used by the top-level RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// File: design/tscu_pkg.sv
// Shared types and constants of the triggered sample capture unit.
// No dependencies; imported by all tscu modules.
package tscu_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int SLOT_LIMIT  = (NUM_SLOTS > 8) ? 8 : NUM_SLOTS;
   localparam logic [3:0] SLOT_LIMIT_4 = 4'(SLOT_LIMIT);

   localparam int DATA_W      = 32;
   localparam int CTRL_W      = 16;
   localparam int CSR_IDX_W   = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [3:0] MODE_UGT    = 4'd0;
   localparam logic [3:0] MODE_ULT    = 4'd1;
   localparam logic [3:0] MODE_SGT    = 4'd2;
   localparam logic [3:0] MODE_SLT    = 4'd3;
   localparam logic [3:0] MODE_EQ     = 4'd4;
   localparam logic [3:0] MODE_NE     = 4'd5;
   localparam logic [3:0] MODE_ALWAYS = 4'd6;

   localparam int CTRL_DONE_BIT   = 12;
   localparam int CTRL_ACTIVE_BIT = 13;
   localparam int CTRL_CONT_BIT   = 14;
   localparam int CTRL_ARM_BIT    = 15;

   typedef struct packed {
      logic [DATA_W-1:0] sample_0;
      logic [DATA_W-1:0] sample_1;
      logic [DATA_W-1:0] sample_2;
      logic [DATA_W-1:0] sample_3;
      logic [DATA_W-1:0] sample_4;
      logic [DATA_W-1:0] sample_5;
      logic [DATA_W-1:0] sample_6;
      logic [DATA_W-1:0] sample_7;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        channel_index;
      logic [DATA_W-1:0] sample_value;
      logic              last;
      logic              done_flag;
      logic              active_flag;
      logic              armed_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0][DATA_W-1:0] samples;
      logic [3:0]             count;
      logic                   done;
      logic                   active;
      logic                   armed;
   } job_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic       busy;
      logic [2:0] idx;
      logic [3:0] count;
   } back_status_type;

endpackage

// File: design/triggered_sample_capture_unit.sv
// Channel  Handshake             Payload
// req      req_valid/req_stall   req_data   (eight 32-bit samples per tick)
// rsp      rsp_valid/rsp_stall   rsp_data   (one slot sample per response)
// csr      csr_valid/csr_ready   csr_index, csr_data
//
// The front end takes a tick while the queue is not full; a capturing tick with n slots
// yields n responses at one per cycle from the back end while rsp_stall is low, so the
// sustained tick rate is set by the back end's single response port.
// A two-entry job queue lets ticks be taken while responses drain.
// Synchronous reset clears registers, capture state and queue; no clear pass.
// Depends on tscu_pkg, tscu_front, tscu_queue, tscu_back, assert_macros.svh.
`include "assert_macros.svh"

module triggered_sample_capture_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tscu_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tscu_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tscu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tscu_pkg::DATA_W-1:0]     csr_data
);
   import tscu_pkg::*;

   logic             push, pop;
   job_type          push_job, head_job;
   queue_status_type q_status;
   back_status_type  b_status;

   assign csr_ready = 1'b1;

   tscu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .push_job  (push_job),
      .q_status  (q_status)
   );

   tscu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   tscu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (b_status)
   );

   `ASSERT_NEVER(a_push_full, clock, reset, push && q_status.full, "push into full queue")
   `ASSERT_IMPLY(a_idx_range, clock, reset, b_status.busy, ({1'b0, b_status.idx} < b_status.count) && (b_status.count != 4'd0), "slot index out of job range")
   `ASSERT_IMPLY(a_q_bound, clock, reset, 1'b1, q_status.count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

// File: design/tscu_front.sv
// Front end: register file, trigger evaluation and capture state per tick.
// Depends on tscu_pkg; pushes one job per accepted emitting tick with a nonzero slot count into tscu_queue.
module tscu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tscu_pkg::req_payload_type           req_data,
   input  logic                                csr_valid,
   input  logic [tscu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tscu_pkg::DATA_W-1:0]         csr_data,
   output logic                                push,
   output tscu_pkg::job_type                   push_job,
   input  tscu_pkg::queue_status_type          q_status
);
   import tscu_pkg::*;

   logic [CTRL_W-1:0] control_ff;
   logic [DATA_W-1:0] limit_ff;
   logic [DATA_W-1:0] threshold_ff;
   logic              armed_ff, active_ff, done_ff;
   logic [DATA_W-1:0] count_ff;

   logic              armed_in, active_in, done_in;
   logic [DATA_W-1:0] count_in;

   logic [7:0][DATA_W-1:0] samples;
   logic [3:0]        slots_req, n_sat, tslot;
   logic [DATA_W-1:0] trig_val;
   logic              hit, emit, accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      samples = {req_data.sample_7, req_data.sample_6, req_data.sample_5,
                 req_data.sample_4, req_data.sample_3, req_data.sample_2,
                 req_data.sample_1, req_data.sample_0};
      slots_req = control_ff[11:8];
      n_sat     = (slots_req > SLOT_LIMIT_4) ? SLOT_LIMIT_4 : slots_req;
      tslot     = control_ff[7:4];
      trig_val  = (tslot < SLOT_LIMIT_4) ? samples[tslot[2:0]] : '0;

      case (control_ff[3:0])
         MODE_UGT:    hit = trig_val > threshold_ff;
         MODE_ULT:    hit = trig_val < threshold_ff;
         MODE_SGT:    hit = $signed(trig_val) > $signed(threshold_ff);
         MODE_SLT:    hit = $signed(trig_val) < $signed(threshold_ff);
         MODE_EQ:     hit = trig_val == threshold_ff;
         MODE_NE:     hit = trig_val != threshold_ff;
         MODE_ALWAYS: hit = 1'b1;
         default:     hit = 1'b0;
      endcase

      armed_in  = armed_ff;
      active_in = active_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      if (armed_ff) begin
         if (hit) begin
            active_in = 1'b1;
         end
         if (active_in) begin
            armed_in = 1'b0;
            count_in = '0;
         end
      end
      emit = active_in || control_ff[CTRL_CONT_BIT];
      if (emit) begin
         count_in = count_in + 1'b1;
         if (count_in == limit_ff) begin
            done_in   = 1'b1;
            active_in = 1'b0;
         end
      end

      push            = accept && emit && (n_sat != 4'd0);
      push_job.samples = samples;
      push_job.count   = n_sat;
      push_job.done    = done_in;
      push_job.active  = active_in;
      push_job.armed   = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= '0;
         limit_ff     <= '0;
         threshold_ff <= '0;
         armed_ff     <= 1'b0;
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         count_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CONTROL: begin
               control_ff <= csr_data[CTRL_W-1:0];
               done_ff    <= csr_data[CTRL_DONE_BIT];
               active_ff  <= csr_data[CTRL_ACTIVE_BIT];
               armed_ff   <= csr_data[CTRL_ARM_BIT];
            end
            CSR_LIMIT:     limit_ff     <= csr_data;
            CSR_THRESHOLD: threshold_ff <= csr_data;
            default: ;
         endcase
      end else if (accept) begin
         armed_ff  <= armed_in;
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/tscu_queue.sv
// Short job queue between front and back end.
// Depends on tscu_pkg for job_type and depth constants.
module tscu_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tscu_pkg::job_type           push_job,
   input  logic                        pop,
   output tscu_pkg::job_type           head_job,
   output tscu_pkg::queue_status_type  status
);
   import tscu_pkg::*;

   job_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QPTR_W-1:0] wr_ptr_in, rd_ptr_in;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      head_job     = entries_ff[rd_ptr_ff];
      status.valid = count_ff != '0;
      status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
      status.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: design/tscu_back.sv
// Back end: walks the slots of one job and drives the registered response.
// Depends on tscu_pkg; pops jobs from tscu_queue.
module tscu_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tscu_pkg::queue_status_type   q_status,
   input  tscu_pkg::job_type            head_job,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tscu_pkg::rsp_payload_type    rsp_data,
   output tscu_pkg::back_status_type    status
);
   import tscu_pkg::*;

   job_type         job_ff;
   logic            busy_ff;
   logic [2:0]      idx_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic            out_free, send, last_now;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign send     = busy_ff && out_free;
   assign last_now = ({1'b0, idx_ff} + 4'd1) == job_ff.count;
   assign pop      = q_status.valid && (!busy_ff || (send && last_now));

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign status.busy  = busy_ff;
   assign status.idx   = idx_ff;
   assign status.count = job_ff.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (send && last_now) begin
            busy_ff <= 1'b0;
         end else if (send) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (send) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (send) begin
         rsp_ff.channel_index <= idx_ff;
         rsp_ff.sample_value  <= job_ff.samples[idx_ff];
         rsp_ff.last          <= last_now;
         rsp_ff.done_flag     <= job_ff.done;
         rsp_ff.active_flag   <= job_ff.active;
         rsp_ff.armed_flag    <= job_ff.armed;
      end
   end

endmodule

// File: tb/sv/tb_triggered_sample_capture_unit.sv
// Self-checking testbench for triggered_sample_capture_unit: directed trigger and capture
// cases, then randomized capture sessions, all scored against an in-bench capture predictor.
// Depends on tscu_pkg and the triggered_sample_capture_unit RTL.
`timescale 1ns / 100ps

module tb_triggered_sample_capture_unit;
   import tscu_pkg::*;

   localparam logic [3:0] MODE_RSVD_FIRST = 4'd7;
   localparam logic [3:0] MODE_RSVD_LAST = 4'd15;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_TICKS = 450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   // capture predictor state
   logic [15:0] ctrl_word = '0;
   logic [31:0] limit_word = '0;
   logic [31:0] thresh_word = '0;
   logic cap_armed = 1'b0;
   logic cap_active = 1'b0;
   logic cap_done = 1'b0;
   logic [31:0] tick_count = '0;

   req_payload_type pending_ticks[$];
   rsp_payload_type expected_samples[$];
   rsp_payload_type head_sample;
   int send_idle_pct = 8;
   int recv_stall_pct = 49;
   int fail_count = 0;
   int ticks_queued = 0;

   triggered_sample_capture_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
         CSR_CONTROL: begin
            ctrl_word = value[15:0];
            cap_done = value[CTRL_DONE_BIT];
            cap_active = value[CTRL_ACTIVE_BIT];
            cap_armed = value[CTRL_ARM_BIT];
         end
         CSR_LIMIT: limit_word = value;
         CSR_THRESHOLD: thresh_word = value;
         default: ;
      endcase
   endfunction

   function automatic void predict_tick(req_payload_type t);
      logic [7:0][31:0] w;
      logic [3:0] n;
      logic [3:0] tslot;
      logic [31:0] v;
      logic hit;
      rsp_payload_type r;
      w = t;
      n = ctrl_word[11:8];
      if (n > SLOT_LIMIT_4) n = SLOT_LIMIT_4;
      tslot = ctrl_word[7:4];
      if (cap_armed) begin
         v = (tslot < SLOT_LIMIT_4) ? w[7 - tslot[2:0]] : '0;
         case (ctrl_word[3:0])
            MODE_UGT: hit = v > thresh_word;
            MODE_ULT: hit = v < thresh_word;
            MODE_SGT: hit = $signed(v) > $signed(thresh_word);
            MODE_SLT: hit = $signed(v) < $signed(thresh_word);
            MODE_EQ: hit = v == thresh_word;
            MODE_NE: hit = v != thresh_word;
            MODE_ALWAYS: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         if (hit) cap_active = 1'b1;
         if (cap_active) begin
            cap_armed = 1'b0;
            tick_count = '0;
         end
      end
      if (cap_active || ctrl_word[CTRL_CONT_BIT]) begin
         tick_count = tick_count + 1;
         if (tick_count == limit_word) begin
            cap_done = 1'b1;
            cap_active = 1'b0;
         end
         for (int i = 0; i < n; i++) begin
            r.channel_index = i[2:0];
            r.sample_value = w[7 - i];
            r.last = (i == n - 1);
            r.done_flag = cap_done;
            r.active_flag = cap_active;
            r.armed_flag = cap_armed;
            expected_samples.push_back(r);
         end
      end
   endfunction

   function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
         fail_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_tick(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_ticks.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               head_sample = expected_samples.pop_front();
               check_field("channel_index", head_sample.channel_index, rsp_data.channel_index);
               check_field("sample_value", head_sample.sample_value, rsp_data.sample_value);
               check_field("last", head_sample.last, rsp_data.last);
               check_field("done_flag", head_sample.done_flag, rsp_data.done_flag);
               check_field("active_flag", head_sample.active_flag, rsp_data.active_flag);
               check_field("armed_flag", head_sample.armed_flag, rsp_data.armed_flag);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic logic [15:0] ctrl_of(logic [3:0] mode, logic [3:0] slot,
         logic [3:0] chans, logic done_b, logic active_b, logic cont_b, logic arm_b);
      logic [15:0] c;
      c = {4'b0, chans, slot, mode};
      c[CTRL_DONE_BIT] = done_b;
      c[CTRL_ACTIVE_BIT] = active_b;
      c[CTRL_CONT_BIT] = cont_b;
      c[CTRL_ARM_BIT] = arm_b;
      return c;
   endfunction

   function automatic req_payload_type make_tick(logic [31:0] fill, int slot, logic [31:0] val);
      logic [7:0][31:0] w;
      for (int i = 0; i < 8; i++) w[i] = fill;
      if (slot < 8) w[7 - slot] = val;
      return w;
   endfunction

   // boundary values: extremes, the sign boundary, the current threshold and its neighbours, or random
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return thresh_word;
         5: return thresh_word + 1;
         6: return thresh_word - 1;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_payload_type random_tick();
      logic [7:0][31:0] w;
      for (int i = 0; i < 8; i++) w[i] = $urandom_range(1) ? $urandom() : pick_word();
      if (ctrl_word[7:4] < 8) w[7 - ctrl_word[6:4]] = pick_word();
      return w;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_flushed();
      while (pending_ticks.size() != 0 || req_valid || expected_samples.size() != 0)
         @(posedge clock);
   endtask

   task automatic settle();
      wait_flushed();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic setup(logic [31:0] thr, logic [31:0] lim, logic [15:0] ctrl);
      settle();
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_LIMIT, lim);
      write_csr(CSR_CONTROL, {16'($urandom()), ctrl});
   endtask

   task automatic trigger_case(logic [3:0] mode, logic [3:0] slot, logic [31:0] thr,
         logic [31:0] val);
      setup(thr, 32'd1, ctrl_of(mode, slot, 4'd2, 1'b0, 1'b0, 1'b0, 1'b1));
      pending_ticks.push_back(make_tick(32'h1234_5678, slot, val));
   endtask

   initial begin
      int burst;
      bit first_session;
      logic [31:0] thr;
      logic [31:0] lim;
      logic [15:0] ctrl;
      first_session = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle after reset: nothing captures
      pending_ticks.push_back(make_tick('0, 8, '0));
      pending_ticks.push_back(make_tick('1, 8, '0));
      settle();
      write_csr(CSR_SPARE, 32'hFFFF_FFFF);

      // continuous capture, limit reached on the third tick
      setup(32'h0, 32'd3, ctrl_of(MODE_UGT, 4'd0, 4'd8, 1'b0, 1'b0, 1'b1, 1'b0));
      pending_ticks.push_back(make_tick('1, 8, '0));
      pending_ticks.push_back(make_tick('0, 8, '0));
      pending_ticks.push_back(make_tick(32'hAAAA_AAAA, 2, 32'h5555_5555));
      pending_ticks.push_back(make_tick(32'h8000_0000, 5, 32'h7FFF_FFFF));

      // channel count saturation, zero channels, single channel
      setup(32'h0, 32'h0, ctrl_of(MODE_UGT, 4'd0, 4'd15, 1'b0, 1'b0, 1'b1, 1'b0));
      pending_ticks.push_back(make_tick(32'hC3C3_3C3C, 7, 32'h0F0F_F0F0));
      setup(32'h0, 32'h0, ctrl_of(MODE_UGT, 4'd0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0));
      pending_ticks.push_back(make_tick(32'h0000_0001, 8, '0));
      setup(32'h0, 32'h0, ctrl_of(MODE_UGT, 4'd0, 4'd1, 1'b0, 1'b0, 1'b1, 1'b0));
      pending_ticks.push_back(make_tick(32'hFEDC_BA98, 8, '0));

      // each trigger mode, reserved codes, out-of-range trigger slot
      trigger_case(MODE_UGT, 4'd0, 32'h8000_0000, 32'h8000_0001);
      trigger_case(MODE_ULT, 4'd1, 32'h8000_0000, 32'h8000_0000);
      trigger_case(MODE_SGT, 4'd2, 32'h0, 32'h7FFF_FFFF);
      trigger_case(MODE_SLT, 4'd3, 32'h0, 32'hFFFF_FFFF);
      trigger_case(MODE_EQ, 4'd4, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
      trigger_case(MODE_NE, 4'd5, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
      trigger_case(MODE_ALWAYS, 4'd7, 32'hFFFF_FFFF, 32'h0);
      trigger_case(MODE_RSVD_FIRST, 4'd6, 32'h0, 32'hFFFF_FFFF);
      trigger_case(MODE_RSVD_LAST, 4'd0, 32'h0, 32'hFFFF_FFFF);
      trigger_case(MODE_EQ, 4'd9, 32'h0, 32'h0);

      // armed and active written together
      setup(32'h0, 32'd2, ctrl_of(MODE_RSVD_LAST, 4'd0, 4'd3, 1'b1, 1'b1, 1'b0, 1'b1));
      repeat (3) pending_ticks.push_back(make_tick(32'h5A5A_A5A5, 8, '0));

      while (ticks_queued < RANDOM_TICKS) begin
         if (ticks_queued >= 300) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (ticks_queued >= 150) begin
            send_idle_pct = 49;
            recv_stall_pct = 8;
         end
         case ($urandom_range(5))
            0: thr = '0;
            1: thr = '1;
            2: thr = 32'h8000_0000;
            3: thr = 32'h7FFF_FFFF;
            default: thr = $urandom();
         endcase
         case ($urandom_range(9))
            0: lim = '0;
            1: lim = '1;
            default: lim = $urandom_range(1, 8);
         endcase
         ctrl = ctrl_of(
            ($urandom_range(9) < 8) ? 4'($urandom_range(MODE_UGT, MODE_ALWAYS))
                                    : 4'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST)),
            ($urandom_range(7) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(7)),
            ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8)),
            1'($urandom_range(1)), ($urandom_range(4) == 0), ($urandom_range(4) == 0),
            ($urandom_range(3) != 0));
         setup(thr, lim, ctrl);
         burst = $urandom_range(3, 12);
         for (int k = 0; k < burst; k++) begin
            // sender may hold off mid-burst until all responses are back
            if (k == burst / 2 && (first_session || $urandom_range(4) == 0)) wait_flushed();
            pending_ticks.push_back(random_tick());
            ticks_queued++;
         end
         first_session = 1'b0;
      end

      settle();
      if (fail_count == 0)
         $display("triggered_sample_capture_unit test passed");
      else
         $display("triggered_sample_capture_unit test failed");
      $finish;
   end

   initial begin
      #400_000;
      $display("triggered_sample_capture_unit test failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/tscu_pkg.sv
design/tscu_front.sv
design/tscu_queue.sv
design/tscu_back.sv
design/triggered_sample_capture_unit.sv
tb/sv/tb_triggered_sample_capture_unit.sv
